[design/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on clk_i, off while rst_ni is low.
`define BVC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Overlapping implication form.
`define BVC_ASSERT_IMP(lbl, ante, cons, msg) \
  `BVC_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication form.
`define BVC_ASSERT_NXT(lbl, ante, cons, msg) \
  `BVC_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

[design/bvc_pkg.sv]
// Types and constants for the base V word converter.
`timescale 1ns / 1ps

package bvc_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned CNT_W     = $clog2(WORD_BITS);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  // Inverse of -3 modulo 2^WORD_BITS, and -3 itself.
  localparam word_t INV_NEG3 = {(WORD_BITS/2){2'b01}};
  localparam word_t NEG3     = ~word_t'(2);

  localparam cnt_t CNT_LAST  = cnt_t'(WORD_BITS - 1);
  localparam cnt_t REV_FIRST = cnt_t'(3);

  typedef enum logic [1:0] {
    MUL_ACC,   // acc * base
    MUL_SQR,   // base * base
    MUL_NEG3   // acc * -3
  } mul_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POW_ACC,
    ST_POW_SQR,
    ST_DIGIT,
    ST_DONE
  } state_e;

endpackage

[design/bvc_mul.sv]
// Shared multiplier with operand selection, low word of the product.
`timescale 1ns / 1ps

module bvc_mul import bvc_pkg::*; (
  input  mul_sel_e sel_i,
  input  word_t    acc_i,
  input  word_t    base_i,
  output word_t    prod_o
);

  word_t op_a;
  word_t op_b;

  always_comb begin
    unique case (sel_i)
      MUL_ACC: begin
        op_a = acc_i;
        op_b = base_i;
      end
      MUL_SQR: begin
        op_a = base_i;
        op_b = base_i;
      end
      MUL_NEG3: begin
        op_a = acc_i;
        op_b = NEG3;
      end
      default: begin
        op_a = acc_i;
        op_b = base_i;
      end
    endcase
  end

  assign prod_o = word_t'(op_a * op_b);

endmodule

[design/base_v_binary_conversion.sv]
// Top level of the base V word converter.
`timescale 1ns / 1ps

// Converts a 32-bit word between binary (tuser = 0) and base V (tuser = 1).
// One item at a time through a single 32x32 multiplier. A forward conversion
// is 32 square-and-multiply steps of K^x, each an accumulate and a square,
// and 32 digit steps of g*(-3)^n. A reverse conversion runs 29 forward
// conversions, one per base V digit from digit 3 up. The DONE state then
// hands the word to the output register once that register is free. The
// input is taken again as soon as the result sits in the output register.
module base_v_binary_conversion import bvc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] operand
  input  logic        s_axis_tuser_i,   // [0] func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [31:0] converted
);

  state_e   state_q, state_d;
  logic     out_valid_q, out_valid_d;
  word_t    out_data_q, out_data_d;
  logic     func_q, func_d;
  word_t    v_q, v_d;
  word_t    b_q, b_d;
  word_t    exp_q, exp_d;
  word_t    acc_q, acc_d;
  word_t    base_q, base_d;
  word_t    f_q, f_d;
  word_t    res_q, res_d;
  cnt_t     cnt_q, cnt_d;
  cnt_t     n_q, n_d;
  mul_sel_e mul_sel;
  word_t    prod;
  word_t    fwd_res;
  word_t    b_flip;
  logic     s_fire;
  logic     out_free;

  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;

  bvc_mul u_mul (
    .sel_i  (mul_sel),
    .acc_i  (acc_q),
    .base_i (base_q),
    .prod_o (prod)
  );

  // Forward word including the digit taken this cycle.
  always_comb begin
    fwd_res        = f_q;
    fwd_res[cnt_q] = acc_q[cnt_q];
    b_flip         = b_q;
    if (fwd_res[n_q] ^ v_q[n_q]) begin
      b_flip[n_q - cnt_t'(2)] = ~b_q[n_q - cnt_t'(2)];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (s_fire) state_d = ST_POW_ACC;
      ST_POW_ACC: state_d = ST_POW_SQR;
      ST_POW_SQR: state_d = (cnt_q == CNT_LAST) ? ST_DIGIT : ST_POW_ACC;
      ST_DIGIT: begin
        if (cnt_q == CNT_LAST) begin
          state_d = (!func_q || n_q == CNT_LAST) ? ST_DONE : ST_POW_ACC;
        end
      end
      ST_DONE:    if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    mul_sel         = MUL_ACC;
    func_d          = func_q;
    v_d             = v_q;
    b_d             = b_q;
    exp_d           = exp_q;
    acc_d           = acc_q;
    base_d          = base_q;
    f_d             = f_q;
    res_d           = res_q;
    cnt_d           = cnt_q;
    n_d             = n_q;
    out_data_d      = out_data_q;
    out_valid_d     = out_valid_q && !m_axis_tready_i;

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          func_d = s_axis_tuser_i;
          v_d    = s_axis_tdata_i;
          b_d    = word_t'(s_axis_tdata_i[2]);
          exp_d  = s_axis_tuser_i ? word_t'(s_axis_tdata_i[2]) : s_axis_tdata_i;
          acc_d  = word_t'(1);
          base_d = INV_NEG3;
          cnt_d  = '0;
          n_d    = REV_FIRST;
        end
      end
      ST_POW_ACC: begin
        mul_sel = MUL_ACC;
        if (exp_q[cnt_q]) acc_d = prod;
      end
      ST_POW_SQR: begin
        mul_sel = MUL_SQR;
        base_d  = prod;
        if (cnt_q == CNT_LAST) begin
          cnt_d = '0;
          f_d   = '0;
        end else begin
          cnt_d = cnt_q + cnt_t'(1);
        end
      end
      ST_DIGIT: begin
        mul_sel = MUL_NEG3;
        acc_d   = prod;
        f_d     = fwd_res;
        if (cnt_q == CNT_LAST) begin
          if (!func_q) begin
            res_d = fwd_res;
          end else if (n_q == CNT_LAST) begin
            res_d = b_flip;
          end else begin
            // Next reverse step: forward-convert the updated guess.
            b_d    = b_flip;
            exp_d  = b_flip;
            acc_d  = word_t'(1);
            base_d = INV_NEG3;
            cnt_d  = '0;
            n_d    = n_q + cnt_t'(1);
          end
        end else begin
          cnt_d = cnt_q + cnt_t'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_data_d  = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    v_q        <= v_d;
    b_q        <= b_d;
    exp_q      <= exp_d;
    acc_q      <= acc_d;
    base_q     <= base_d;
    f_q        <= f_d;
    res_q      <= res_d;
    cnt_q      <= cnt_d;
    n_q        <= n_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

[design/bvc_checker.sv]
// Port-level checks for the base V word converter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bvc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o
);

  `BVC_ASSERT_NXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o, "output transaction dropped while stalled")
  `BVC_ASSERT_NXT(a_out_stable, m_axis_tvalid_o && !m_axis_tready_i, $stable(m_axis_tdata_o), "output data changed while stalled")
  `BVC_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "input taken again while converting")
  `BVC_ASSERT_IMP(a_result_busy, $rose(m_axis_tvalid_o), !$past(s_axis_tready_o), "result appeared without a conversion in flight")

endmodule

bind base_v_binary_conversion bvc_checker u_bvc_checker (.*);

[sim/tb_top.sv]
// Testbench for the base V word converter: directed table, random items, self-checking.
`timescale 1ns / 1ps

module tb_top;
  import bvc_pkg::word_t;

  typedef enum logic {
    FUNC_TO_BASE_V = 1'b0,
    FUNC_TO_BINARY = 1'b1
  } conv_func_e;

  typedef struct packed {
    conv_func_e func;
    word_t      operand;
  } conv_row_t;

  localparam int unsigned N_RANDOM     = 290;
  localparam int unsigned PAUSE_AT     = 150;
  localparam int unsigned HOLD_CYCLES  = 6000;
  localparam int unsigned DRAIN_CYCLES = 3000;
  localparam longint unsigned LIMIT    = 64'd4_000_000;
  localparam word_t K_INV_NEG3         = 32'h5555_5555;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;    // [31:0] operand
  logic        s_axis_tuser_i = 1'b0;  // [0] func
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;         // [31:0] converted

  word_t           converted_due[$];
  word_t           due_word;
  int unsigned     results_seen = 0;
  int unsigned     n_forward = 0;
  int unsigned     n_reverse = 0;
  int unsigned     errors = 0;
  bit              sender_calm = 1'b0;
  bit              rx_held = 1'b0;
  longint unsigned cycle_cnt = 0;

  // Forward and reverse cases at the field extremes; no expected word is
  // obvious by eye here, so every row goes through the predictor.
  conv_row_t dir_rows [19] = '{
    '{FUNC_TO_BASE_V, 32'h0000_0000},
    '{FUNC_TO_BASE_V, 32'h0000_0001},
    '{FUNC_TO_BASE_V, 32'h0000_0002},
    '{FUNC_TO_BASE_V, 32'h0000_0004},
    '{FUNC_TO_BASE_V, 32'h7FFF_FFFF},
    '{FUNC_TO_BASE_V, 32'h8000_0000},
    '{FUNC_TO_BASE_V, 32'hFFFF_FFFF},
    '{FUNC_TO_BASE_V, 32'h5555_5555},
    '{FUNC_TO_BASE_V, 32'hAAAA_AAAA},
    '{FUNC_TO_BINARY, 32'h0000_0000},
    '{FUNC_TO_BINARY, 32'h0000_0001},
    '{FUNC_TO_BINARY, 32'h0000_0004},
    '{FUNC_TO_BINARY, 32'h0000_0008},
    '{FUNC_TO_BINARY, 32'h7FFF_FFFF},
    '{FUNC_TO_BINARY, 32'h8000_0000},
    '{FUNC_TO_BINARY, 32'hFFFF_FFFF},
    '{FUNC_TO_BINARY, 32'h5555_5555},
    '{FUNC_TO_BINARY, 32'hAAAA_AAAA},
    '{FUNC_TO_BINARY, 32'hDEAD_BEEF}
  };

  base_v_binary_conversion DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #6 clk_i = ~clk_i;

  // (-3)^(-x) as K^x, square and multiply, wrapping at the word width
  function automatic word_t inv_neg3_pow(input word_t x);
    word_t acc;
    word_t base;
    acc  = 32'd1;
    base = K_INV_NEG3;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) acc = acc * base;
      base = base * base;
    end
    return acc;
  endfunction

  function automatic word_t binary_to_base_v(input word_t x);
    word_t g;
    word_t f;
    g = inv_neg3_pow(x);
    f = '0;
    for (int n = 0; n < 32; n++) begin
      f[n] = g[n];
      g = 32'd0 - 32'd3 * g;
    end
    return f;
  endfunction

  // Rebuild the binary word one bit at a time, from bit 3 of the base V word up
  function automatic word_t base_v_to_binary(input word_t v);
    word_t b;
    word_t diff;
    b = word_t'(v[2]);
    for (int n = 3; n < 32; n++) begin
      diff = binary_to_base_v(b) ^ v;
      if (diff[n]) b ^= word_t'(1) << (n - 2);
    end
    return b;
  endfunction

  function automatic word_t convert_word(input conv_func_e f, input word_t op);
    return (f == FUNC_TO_BINARY) ? base_v_to_binary(op) : binary_to_base_v(op);
  endfunction

  task automatic send_conversion(input conv_func_e f, input word_t op);
    while (!sender_calm && $urandom_range(99) < 29) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= $urandom();
      s_axis_tuser_i  <= 1'($urandom_range(1));
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= op;
    s_axis_tuser_i  <= f;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    converted_due.push_back(convert_word(f, op));
    if (f == FUNC_TO_BINARY) n_reverse++;
    else n_forward++;
  endtask

  // Sender stops offering until every pending conversion has come back
  task automatic wait_all_converted();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (converted_due.size() != 0);
  endtask

  function automatic word_t random_operand(input conv_func_e f);
    word_t op;
    case ($urandom_range(4))
      0: op = $urandom_range(63);
      1: op = word_t'(1) << $urandom_range(31);
      2: op = ~(word_t'(1) << $urandom_range(31));
      // well-formed base V word from a random binary value
      3: op = (f == FUNC_TO_BINARY) ? binary_to_base_v($urandom()) : $urandom();
      default: op = $urandom();
    endcase
    return op;
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (converted_due.size() == 0) begin
        $error("converted: no transaction pending, actual %08h", m_axis_tdata_o);
        errors++;
      end else begin
        due_word = converted_due.pop_front();
        if (m_axis_tdata_o !== due_word) begin
          $error("converted: expected %08h, actual %08h", due_word, m_axis_tdata_o);
          errors++;
        end
      end
      results_seen <= results_seen + 1;
    end
  end

  // Receiver backpressure: random stalls, one long hold-off, one calm stretch
  initial begin
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!rx_held && results_seen >= 40) begin
        rx_held = 1'b1;
        repeat (HOLD_CYCLES) begin
          m_axis_tready_i <= 1'b0;
          @(posedge clk_i);
        end
      end else begin
        if (results_seen >= 100 && results_seen < 170) m_axis_tready_i <= 1'b1;
        else m_axis_tready_i <= ($urandom_range(99) >= 29);
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    conv_func_e f;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_conversion(dir_rows[i].func, dir_rows[i].operand);
    wait_all_converted();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == PAUSE_AT) wait_all_converted();
      sender_calm = (i >= 200 && i < 260);
      f = conv_func_e'($urandom_range(1));
      send_conversion(f, random_operand(f));
    end
    s_axis_tvalid_i <= 1'b0;

    do @(posedge clk_i); while (converted_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (converted_due.size() != 0) begin
      $error("converted: %0d transactions never returned", converted_due.size());
      errors++;
    end

    $display("Run covered %0d binary-to-base-V and %0d base-V-to-binary conversions,",
             n_forward, n_reverse);
    $display("%0d results compared, %0d mismatches", results_seen, errors);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/bvc_pkg.sv
design/bvc_mul.sv
design/base_v_binary_conversion.sv
design/bvc_checker.sv
sim/tb_top.sv
